// ===== hw/rtl/isd_pkg.sv =====
`timescale 1ns / 1ps
package isd_pkg;

	// sizes
	localparam int MAX_BODIES  = 256;
	localparam int SLOT_W      = 8;
	localparam int VEL_W       = 16;
	localparam int TIME_W      = 16;
	localparam int SPD_W       = 16;
	localparam int SQ_W        = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [TIME_W-1:0] REST_MAX = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_EN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIN_SPEED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ANG_SPEED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_WAIT = 3'd4;

	// configuration reset values
	localparam logic [SPD_W-1:0]  LIN_SPEED_RST = 16'd5;
	localparam logic [SPD_W-1:0]  ANG_SPEED_RST = 16'd13;
	localparam logic [TIME_W-1:0] TIME_STEP_RST = 16'd17;
	localparam logic [TIME_W-1:0] TIME_WAIT_RST = 16'd1024;
	localparam logic [SQ_W-1:0]   LIN_THR_RST   = SQ_W'(5 * 5);
	localparam logic [SQ_W-1:0]   ANG_THR_RST   = SQ_W'(13 * 13);

	// body operations decided by the front end
	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_SKIP  = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_GROW  = 2'd2;

	typedef struct packed {
		logic signed [VEL_W-1:0] lin_vx;
		logic signed [VEL_W-1:0] lin_vy;
		logic signed [VEL_W-1:0] lin_vz;
		logic signed [VEL_W-1:0] ang_wx;
		logic signed [VEL_W-1:0] ang_wy;
		logic signed [VEL_W-1:0] ang_wz;
		logic                    is_static;
		logic                    may_sleep;
		logic [SLOT_W-1:0]       body_index;
		logic                    island_last;
	} isd_body_t;

	typedef struct packed {
		logic [SLOT_W-1:0] body_id;
		logic [TIME_W-1:0] rest_time;
		logic              island_end;
		logic              island_sleeps;
	} isd_result_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} isd_cmd_t;

	typedef struct packed {
		logic              sleep_en;
		logic [SQ_W-1:0]   lin_thr_sq;
		logic [SQ_W-1:0]   ang_thr_sq;
		logic [TIME_W-1:0] time_step;
		logic [TIME_W-1:0] time_wait;
	} isd_cfg_t;

endpackage

// ===== hw/rtl/isd_chan_if.sv =====
`timescale 1ns / 1ps
interface isd_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/island_sleep_detector.sv =====
`timescale 1ns / 1ps
// channel  dir  payload        handshake
// body     in   isd_body_t     valid / ready
// result   out  isd_result_t   valid / ready
// cfg      in   idx, wdata     cfg_we, no ready
//
// one body per cycle sustained while the result side is ready, one result per body, in order
// from request to result a body passes two front stages,
// one queue slot, the timer memory read stage and the output register
// same-index bodies back to back take the fresh timer through a bypass
// asynchronous reset, timers read as zero until first written, no sweep
// front and back stall independently across a four-entry queue
module island_sleep_detector (
	input  logic                               clk,
	input  logic                               arst_n,
	isd_chan_if.sink                           body,
	isd_chan_if.source                         result,
	input  logic                               cfg_we,
	input  logic [isd_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [isd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import isd_pkg::*;

	logic              sleep_en_q;
	logic [SPD_W-1:0]  lin_speed_q, ang_speed_q;
	logic [TIME_W-1:0] time_step_q, time_wait_q;
	logic [SQ_W-1:0]   lin_thr_q, ang_thr_q;
	isd_cfg_t          cfg;
	isd_cmd_t          fr_cmd, bk_cmd;
	logic              fr_valid, fr_ready, bk_valid, bk_ready;

	// configuration registers and squared thresholds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_en_q  <= 1'b1;
			lin_speed_q <= LIN_SPEED_RST;
			ang_speed_q <= ANG_SPEED_RST;
			time_step_q <= TIME_STEP_RST;
			time_wait_q <= TIME_WAIT_RST;
			lin_thr_q   <= LIN_THR_RST;
			ang_thr_q   <= ANG_THR_RST;
		end else begin
			lin_thr_q <= SQ_W'(lin_speed_q) * SQ_W'(lin_speed_q);
			ang_thr_q <= SQ_W'(ang_speed_q) * SQ_W'(ang_speed_q);
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_SLEEP_EN:  sleep_en_q  <= cfg_wdata[0];
					CFG_LIN_SPEED: lin_speed_q <= cfg_wdata[SPD_W-1:0];
					CFG_ANG_SPEED: ang_speed_q <= cfg_wdata[SPD_W-1:0];
					CFG_TIME_STEP: time_step_q <= cfg_wdata[TIME_W-1:0];
					CFG_TIME_WAIT: time_wait_q <= cfg_wdata[TIME_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		cfg.sleep_en   = sleep_en_q;
		cfg.lin_thr_sq = lin_thr_q;
		cfg.ang_thr_sq = ang_thr_q;
		cfg.time_step  = time_step_q;
		cfg.time_wait  = time_wait_q;
	end

	isd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.body      (body),
		.cfg       (cfg),
		.cmd       (fr_cmd),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready)
	);

	isd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (fr_cmd),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.pop_data   (bk_cmd),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready)
	);

	isd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (bk_cmd),
		.cmd_valid (bk_valid),
		.cmd_ready (bk_ready),
		.cfg       (cfg),
		.result    (result)
	);
endmodule

// ===== hw/rtl/isd_front.sv =====
`timescale 1ns / 1ps
module isd_front (
	input  logic              clk,
	input  logic              arst_n,
	isd_chan_if.sink          body,
	input  isd_pkg::isd_cfg_t cfg,
	output isd_pkg::isd_cmd_t cmd,
	output logic              cmd_valid,
	input  logic              cmd_ready
);
	import isd_pkg::*;

	function automatic logic [SQ_W-1:0] square(input logic signed [VEL_W-1:0] v);
		logic signed [SQ_W-1:0] w;
		w = SQ_W'(v);
		return $unsigned(w * w);
	endfunction

	logic              v_s1, v_s2;
	logic [SQ_W-1:0]   lx_sq_s1, ly_sq_s1, lz_sq_s1;
	logic [SQ_W-1:0]   ax_sq_s1, ay_sq_s1, az_sq_s1;
	logic              static_s1, may_sleep_s1, last_s1;
	logic [SLOT_W-1:0] slot_s1;
	isd_cmd_t          cmd_s2;
	logic              adv;
	logic [SQ_W-1:0]   lin_sum, ang_sum;
	logic              awake;
	logic [OP_W-1:0]   op;

	// both stages move together whenever the queue can take the oldest request
	assign adv        = !v_s2 || cmd_ready;
	assign body.ready = adv;

	// stage 1: squared velocity components
	always_ff @(posedge clk) begin
		if (adv) begin
			lx_sq_s1     <= square(body.data.lin_vx);
			ly_sq_s1     <= square(body.data.lin_vy);
			lz_sq_s1     <= square(body.data.lin_vz);
			ax_sq_s1     <= square(body.data.ang_wx);
			ay_sq_s1     <= square(body.data.ang_wy);
			az_sq_s1     <= square(body.data.ang_wz);
			static_s1    <= body.data.is_static;
			may_sleep_s1 <= body.data.may_sleep;
			slot_s1      <= body.data.body_index;
			last_s1      <= body.data.island_last;
		end
	end

	// speed test and classification
	assign lin_sum = lx_sq_s1 + ly_sq_s1 + lz_sq_s1;
	assign ang_sum = ax_sq_s1 + ay_sq_s1 + az_sq_s1;
	assign awake   = (lin_sum > cfg.lin_thr_sq) || (ang_sum > cfg.ang_thr_sq) || !may_sleep_s1;

	always_comb begin
		if (!cfg.sleep_en || static_s1) begin
			op = OP_SKIP;
		end else if (awake) begin
			op = OP_CLEAR;
		end else begin
			op = OP_GROW;
		end
	end

	// stage 2: classified request
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2.op   <= op;
			cmd_s2.slot <= slot_s1;
			cmd_s2.last <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= body.valid;
			v_s2 <= v_s1;
		end
	end

	assign cmd       = cmd_s2;
	assign cmd_valid = v_s2;
endmodule

// ===== hw/rtl/isd_queue.sv =====
`timescale 1ns / 1ps
module isd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  isd_pkg::isd_cmd_t push_data,
	input  logic              push_valid,
	output logic              push_ready,
	output isd_pkg::isd_cmd_t pop_data,
	output logic              pop_valid,
	input  logic              pop_ready
);
	import isd_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	isd_cmd_t         entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             push, pop;

	assign push_ready = count_q != (PTR_W+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== hw/rtl/isd_back.sv =====
`timescale 1ns / 1ps
module isd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  isd_pkg::isd_cmd_t cmd,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  isd_pkg::isd_cfg_t cfg,
	isd_chan_if.source        result
);
	import isd_pkg::*;

	logic [TIME_W-1:0]     timer_mem [MAX_BODIES];
	logic [MAX_BODIES-1:0] written_q;

	logic                  v_s1;
	isd_cmd_t              cmd_s1;
	logic [TIME_W-1:0]     mem_rd_s1;
	logic                  mem_vld_s1;
	logic                  byp_hit_s1;
	logic [TIME_W-1:0]     byp_time_s1;

	logic [TIME_W-1:0]     min_q;
	logic                  out_v_q;
	isd_result_t           out_q;

	logic                  adv, pop, commit, wr;
	logic [TIME_W-1:0]     cur_time, new_time, grown, min_next;
	logic [TIME_W:0]       grow_sum;
	isd_result_t           res;

	assign adv       = !out_v_q || result.ready;
	assign cmd_ready = !v_s1 || adv;
	assign pop       = cmd_valid && cmd_ready;
	assign commit    = v_s1 && adv;
	assign wr        = commit && (cmd_s1.op != OP_SKIP);

	// timer memory: registered read on pop, write on a committed non-skip request
	always_ff @(posedge clk) begin
		if (pop) begin
			mem_rd_s1 <= timer_mem[cmd.slot];
		end
		if (wr) begin
			timer_mem[cmd_s1.slot] <= new_time;
		end
	end

	// read stage payload and forwarding of a write made on the same edge
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1      <= cmd;
			mem_vld_s1  <= written_q[cmd.slot];
			byp_hit_s1  <= wr && (cmd_s1.slot == cmd.slot);
			byp_time_s1 <= new_time;
		end
	end

	// current timer: a never-written entry reads as zero
	always_comb begin
		if (byp_hit_s1) begin
			cur_time = byp_time_s1;
		end else if (mem_vld_s1) begin
			cur_time = mem_rd_s1;
		end else begin
			cur_time = '0;
		end
	end

	// saturating timer increment
	assign grow_sum = {1'b0, cur_time} + {1'b0, cfg.time_step};
	assign grown    = grow_sum[TIME_W] ? REST_MAX : grow_sum[TIME_W-1:0];

	always_comb begin
		unique case (cmd_s1.op)
			OP_CLEAR: begin
				new_time = '0;
				min_next = '0;
			end
			OP_GROW: begin
				new_time = grown;
				min_next = (grown < min_q) ? grown : min_q;
			end
			default: begin
				new_time = cur_time;
				min_next = min_q;
			end
		endcase
	end

	always_comb begin
		res.body_id       = cmd_s1.slot;
		res.rest_time     = new_time;
		res.island_end    = cmd_s1.last;
		res.island_sleeps = cmd_s1.last && cfg.sleep_en && (min_next >= cfg.time_wait);
	end

	// output register
	always_ff @(posedge clk) begin
		if (commit) begin
			out_q <= res;
		end
	end

	// control state, island minimum and written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_v_q   <= 1'b0;
			min_q     <= REST_MAX;
			written_q <= '0;
		end else begin
			if (cmd_ready) begin
				v_s1 <= cmd_valid;
			end
			if (adv) begin
				out_v_q <= v_s1;
			end
			if (commit) begin
				min_q <= cmd_s1.last ? REST_MAX : min_next;
			end
			if (wr) begin
				written_q[cmd_s1.slot] <= 1'b1;
			end
		end
	end

	assign result.valid = out_v_q;
	assign result.data  = out_q;
endmodule

// ===== tb/island_sleep_detector_tb.sv =====
`timescale 1ns / 1ps
module island_sleep_detector_tb;
	import isd_pkg::*;

	localparam int ISLAND_PHASES = 10;
	localparam int PHASE_BODIES  = 125;
	localparam int PIPE_SETTLE   = 12;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int MAX_REPORTS   = 10;
	localparam int LONG_HOLD     = 120;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_THREE_OF_FOUR,
		RX_COIN,
		RX_ONE_OF_THREE
	} rx_mode_e;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	isd_chan_if #(.T(isd_body_t))   body_ch ();
	isd_chan_if #(.T(isd_result_t)) result_ch ();

	island_sleep_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.body      (body_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// shadow copy of the configuration and the timer state
	logic              cfg_en;
	logic [SPD_W-1:0]  cfg_lin;
	logic [SPD_W-1:0]  cfg_ang;
	logic [TIME_W-1:0] cfg_tstep;
	logic [TIME_W-1:0] cfg_twait;
	logic [TIME_W-1:0] rest_tmr [MAX_BODIES];
	int                isl_min;

	// body requests waiting to be offered, results still owed by the block
	isd_body_t   body_req_q [$];
	isd_result_t rest_expect_q [$];

	bit       body_fire = 1'b0;
	int       fail_count = 0;
	int       send_burst = 1;
	int       send_gap = 0;
	logic     hold_req = 1'b0;
	logic     hold_done = 1'b0;
	int       hold_left = 0;
	int       rx_seg_left = 0;
	int       rx_tick = 0;
	rx_mode_e rx_mode = RX_OPEN;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint sum_sq(logic signed [VEL_W-1:0] a, logic signed [VEL_W-1:0] b,
			logic signed [VEL_W-1:0] c);
		return longint'(a) * longint'(a) + longint'(b) * longint'(b) + longint'(c) * longint'(c);
	endfunction

	// one body through the timer update and island bookkeeping
	function automatic isd_result_t step_rest_timers(isd_body_t b);
		isd_result_t r;
		longint      lin_sq;
		longint      ang_sq;
		int          t;
		lin_sq = sum_sq(b.lin_vx, b.lin_vy, b.lin_vz);
		ang_sq = sum_sq(b.ang_wx, b.ang_wy, b.ang_wz);
		r = '0;
		if (cfg_en && !b.is_static) begin
			if (lin_sq > longint'(cfg_lin) * longint'(cfg_lin) ||
					ang_sq > longint'(cfg_ang) * longint'(cfg_ang) || !b.may_sleep) begin
				rest_tmr[b.body_index] = '0;
				isl_min = 0;
			end else begin
				t = int'(rest_tmr[b.body_index]) + int'(cfg_tstep);
				if (t > int'(REST_MAX))
					t = int'(REST_MAX);
				rest_tmr[b.body_index] = TIME_W'(t);
				if (t < isl_min)
					isl_min = t;
			end
		end
		r.body_id = b.body_index;
		r.rest_time = rest_tmr[b.body_index];
		r.island_end = b.island_last;
		if (b.island_last) begin
			r.island_sleeps = cfg_en && (isl_min >= int'(cfg_twait));
			isl_min = int'(REST_MAX);
		end
		return r;
	endfunction

	// velocity component whose square stays within a quarter of thr squared
	function automatic logic [VEL_W-1:0] rest_component(logic [SPD_W-1:0] thr);
		int h;
		h = int'(thr) / 2;
		if (h > 32767)
			h = 32767;
		return VEL_W'($urandom_range(0, 2 * h) - h);
	endfunction

	// register value with the extremes weighted in
	function automatic logic [15:0] pick_reg(int lo, int hi);
		int sel;
		sel = $urandom_range(0, 7);
		if (sel == 0)
			return 16'h0000;
		if (sel == 1)
			return 16'hFFFF;
		return 16'($urandom_range(lo, hi));
	endfunction

	task automatic push_body(input logic [15:0] lvx, lvy, lvz, awx, awy, awz,
			input logic st, input logic ms, input logic [7:0] idx, input logic last);
		isd_body_t b;
		b.lin_vx = lvx;
		b.lin_vy = lvy;
		b.lin_vz = lvz;
		b.ang_wx = awx;
		b.ang_wy = awy;
		b.ang_wz = awz;
		b.is_static = st;
		b.may_sleep = ms;
		b.body_index = idx;
		b.island_last = last;
		body_req_q.push_back(b);
	endtask

	// write every register in turn, block idle
	task automatic set_config(input logic en, input logic [15:0] lin, ang, tstep, twait);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_SLEEP_EN;
		cfg_wdata <= CFG_DATA_W'(en);
		@(negedge clk);
		cfg_idx <= CFG_LIN_SPEED;
		cfg_wdata <= lin;
		@(negedge clk);
		cfg_idx <= CFG_ANG_SPEED;
		cfg_wdata <= ang;
		@(negedge clk);
		cfg_idx <= CFG_TIME_STEP;
		cfg_wdata <= tstep;
		@(negedge clk);
		cfg_idx <= CFG_TIME_WAIT;
		cfg_wdata <= twait;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_en = en;
		cfg_lin = lin;
		cfg_ang = ang;
		cfg_tstep = tstep;
		cfg_twait = twait;
	endtask

	// wait for every request taken and every result back
	task automatic drain_results();
		int n;
		n = 0;
		while ((body_req_q.size() != 0 || body_ch.valid || rest_expect_q.size() != 0) &&
				n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (PIPE_SETTLE) @(negedge clk);
	endtask

	// islands over a small pool of bodies so timers climb, with some noise mixed in
	task automatic queue_islands(input int count);
		int          left;
		int          n;
		int          kind;
		logic [7:0]  pool_base;
		logic [7:0]  prev_idx;
		logic [7:0]  idx;
		logic [127:0] raw;
		isd_body_t   b;
		left = count;
		pool_base = 8'($urandom_range(0, 255));
		prev_idx = pool_base;
		while (left > 0) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
			for (int k = 0; k < n && left > 0; k++) begin
				if ($urandom_range(0, 9) < 2) begin
					// fully random body, island mark included
					raw = {$urandom, $urandom, $urandom, $urandom};
					b = raw[$bits(isd_body_t)-1:0];
				end else begin
					kind = $urandom_range(0, 99);
					if ($urandom_range(0, 7) == 0)
						idx = prev_idx;
					else
						idx = pool_base + 8'($urandom_range(0, 7));
					b.lin_vx = rest_component(cfg_lin);
					b.lin_vy = rest_component(cfg_lin);
					b.lin_vz = rest_component(cfg_lin);
					b.ang_wx = rest_component(cfg_ang);
					b.ang_wy = rest_component(cfg_ang);
					b.ang_wz = rest_component(cfg_ang);
					b.is_static = (kind < 8);
					b.may_sleep = !(kind >= 8 && kind < 13);
					b.body_index = idx;
					b.island_last = (k == n - 1);
					if (kind < 8 || (kind >= 13 && kind < 20)) begin
						b.lin_vx = 16'($urandom);
						b.ang_wy = 16'($urandom);
					end else if (kind < 28 && cfg_lin <= 16'd32767) begin
						// exactly on the linear threshold still counts as resting
						b.lin_vx = '0;
						b.lin_vy = '0;
						b.lin_vz = cfg_lin;
					end
				end
				prev_idx = b.body_index;
				body_req_q.push_back(b);
				left--;
			end
		end
	endtask

	// sender: bursts of random length with random gaps
	always @(negedge clk) begin
		isd_body_t nxt;
		logic      offer;
		nxt = body_ch.data;
		offer = body_ch.valid;
		if (arst_n && (!body_ch.valid || body_fire)) begin
			offer = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (body_req_q.size() != 0) begin
				nxt = body_req_q.pop_front();
				offer = 1'b1;
				if (send_burst > 1) begin
					send_burst--;
				end else begin
					send_burst = $urandom_range(1, 24);
					send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		body_ch.valid <= offer;
		body_ch.data <= nxt;
	end

	// receiver: stall patterns in segments, plus long hold-offs
	always @(negedge clk) begin
		logic take;
		take = 1'b1;
		if (hold_left > 0) begin
			hold_left--;
			take = 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
			take = 1'b0;
		end else begin
			if (rx_seg_left == 0) begin
				rx_seg_left = $urandom_range(16, 160);
				rx_mode = rx_mode_e'($urandom_range(0, 3));
			end
			rx_seg_left--;
			rx_tick++;
			case (rx_mode)
				RX_OPEN: take = 1'b1;
				RX_THREE_OF_FOUR: take = (rx_tick % 4) != 0;
				RX_COIN: take = 1'($urandom_range(0, 1));
				default: take = (rx_tick % 3) == 0;
			endcase
			if ($urandom_range(0, 799) == 0)
				hold_left = $urandom_range(30, 90);
		end
		result_ch.ready <= take;
	end

	// monitor: predict on each accepted request, check each accepted result
	always @(posedge clk) begin
		isd_result_t got;
		isd_result_t want;
		body_fire = arst_n && body_ch.valid && body_ch.ready;
		if (body_fire)
			rest_expect_q.push_back(step_rest_timers(body_ch.data));
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (rest_expect_q.size() == 0) begin
				if (fail_count < MAX_REPORTS)
					$display("result with nothing pending: id %0d rest %0d end %0b sleeps %0b",
						got.body_id, got.rest_time, got.island_end, got.island_sleeps);
				fail_count++;
			end else begin
				want = rest_expect_q.pop_front();
				if (got.body_id !== want.body_id || got.rest_time !== want.rest_time ||
						got.island_end !== want.island_end ||
						got.island_sleeps !== want.island_sleeps) begin
					if (fail_count < MAX_REPORTS)
						$display("mismatch: expected id %0d rest %0d end %0b sleeps %0b,",
							want.body_id, want.rest_time, want.island_end,
							want.island_sleeps,
							" got id %0d rest %0d end %0b sleeps %0b",
							got.body_id, got.rest_time, got.island_end,
							got.island_sleeps);
					fail_count++;
				end
			end
		end
	end

	initial begin
		body_ch.valid = 1'b0;
		body_ch.data = '0;
		result_ch.ready = 1'b0;
		cfg_en = 1'b1;
		cfg_lin = LIN_SPEED_RST;
		cfg_ang = ANG_SPEED_RST;
		cfg_tstep = TIME_STEP_RST;
		cfg_twait = TIME_WAIT_RST;
		foreach (rest_tmr[i])
			rest_tmr[i] = '0;
		isl_min = int'(REST_MAX);
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: threshold edges, velocity extremes, static-only island
		push_body(0, 0, 0, 0, 0, 0, 0, 1, 8'd0, 1);
		push_body(16'd5, 0, 0, 0, 0, 0, 0, 1, 8'd255, 0);
		push_body(0, -16'sd6, 0, 0, 0, 0, 0, 1, 8'd1, 1);
		push_body(0, 0, 0, 0, 0, -16'sd13, 0, 1, 8'd2, 0);
		push_body(0, 0, 0, 16'd14, 0, 0, 0, 1, 8'd2, 1);
		push_body(16'd3, 16'd4, 0, 16'd5, 16'd12, 0, 0, 1, 8'd3, 0);
		push_body(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 1, 8'd4, 0);
		push_body(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 1, 8'd5, 0);
		push_body(0, 0, 0, 0, 0, 0, 0, 0, 8'd6, 1);
		push_body(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, 1, 8'd7, 0);
		push_body(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 0, 8'd8, 1);
		drain_results();

		// all maxima: everything rests and timers saturate
		set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_body(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 1, 8'd9, 0);
		push_body(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 1, 8'd9, 1);
		push_body(0, 0, 0, 0, 0, 0, 0, 1, 8'd0, 1);
		drain_results();

		// all zero: any motion wakes, a cleared island still meets a zero wait
		set_config(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		push_body(0, 0, 0, 0, 0, 0, 0, 1, 8'd0, 0);
		push_body(0, 0, 16'd1, 0, 0, 0, 0, 1, 8'd10, 1);
		push_body(0, 0, 0, 0, 0, 16'hFFFF, 0, 1, 8'd11, 1);
		drain_results();

		// sleeping disabled: timers frozen, no island sleeps
		set_config(1'b0, LIN_SPEED_RST, ANG_SPEED_RST, TIME_STEP_RST, 16'h0000);
		push_body(0, 0, 0, 0, 0, 0, 0, 1, 8'd0, 0);
		push_body(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 1, 8'd9, 1);
		push_body(0, 0, 0, 0, 0, 0, 1, 0, 8'd12, 1);
		drain_results();

		// random phases, each under its own settings
		for (int p = 0; p < ISLAND_PHASES; p++) begin
			set_config($urandom_range(0, 5) != 0, pick_reg(1, 600), pick_reg(1, 600),
				pick_reg(60, 700), pick_reg(0, 4000));
			queue_islands(PHASE_BODIES);
			if (p == 2)
				hold_req = 1'b1;
			drain_results();
		end

		if (fail_count == 0 && rest_expect_q.size() == 0)
			$display("island_sleep_detector regression: pass");
		else
			$display("island_sleep_detector regression: fail");
		$finish;
	end

	// run limit
	initial begin
		#400000;
		$display("island_sleep_detector regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/isd_pkg.sv
hw/rtl/isd_chan_if.sv
hw/rtl/isd_front.sv
hw/rtl/isd_queue.sv
hw/rtl/isd_back.sv
hw/rtl/island_sleep_detector.sv
tb/island_sleep_detector_tb.sv
